// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros: assertion helpers shared by the design files
// clocked assertions that are muted while reset is held
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge of clk outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// implication whose consequent is checked in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/etp_pkg.sv =====
// ----------------------------------------------------------------------------
// etp_pkg
// types and codes of the endian table parser
// ----------------------------------------------------------------------------
package etp_pkg;

	// parser phase
	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_HEADER = 3'd1,
		PH_ENTRY  = 3'd2,
		PH_SUB    = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	// record kinds
	typedef enum logic [1:0] {
		KIND_ENTRY   = 2'd0,
		KIND_SUB     = 2'd1,
		KIND_EMPTY   = 2'd2,
		KIND_INVALID = 2'd3
	} kind_t;

	// packed value length prefix
	typedef enum logic [1:0] {
		PFX_ONE  = 2'd0,
		PFX_TWO  = 2'd1,
		PFX_FOUR = 2'd2,
		PFX_BAD  = 2'd3
	} prefix_t;

	localparam int unsigned ValW      = 30;
	localparam int unsigned CountW    = 32;
	localparam logic [3:0]  HdrLast   = 4'd15;
	localparam logic [1:0]  PendTwo   = 2'd1;
	localparam logic [1:0]  PendFour  = 2'd3;

	// one result item
	typedef struct packed {
		kind_t             kind;
		logic [ValW-1:0]   offset_or_skip;
		logic [ValW-1:0]   sub_count;
		logic [ValW-1:0]   element_size;
		logic [ValW-1:0]   repeat_value;
		logic [1:0]        swap_type;
		logic              last;
	} rec_t;

endpackage

// ===== design/endian_table_parser_unit.sv =====
// ----------------------------------------------------------------------------
// endian_table_parser_unit
// record: written into the result buffer as its last byte is accepted
// throughput: one byte per cycle while in_stall is low, set by the single state update per byte
// output: two-slot result buffer, input stalls only when both slots are full
// reset: arst_n clears parser state and empties the buffer, parser goes idle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module endian_table_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	// byte stream
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  byte_value,
	input  logic        start_of_table,
	// records
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  record_kind,
	output logic [29:0] offset_or_skip,
	output logic [29:0] sub_count,
	output logic [29:0] element_size,
	output logic [29:0] repeat_value,
	output logic [1:0]  swap_type,
	output logic        last_record
);

	localparam int unsigned ValW   = etp_pkg::ValW;
	localparam int unsigned CountW = etp_pkg::CountW;

	// parser state
	etp_pkg::phase_t   phase_q;
	logic [3:0]        hidx_q;
	logic [CountW-1:0] ent_q;
	logic [ValW-1:0]   subs_q;
	logic [1:0]        fidx_q;
	logic [1:0]        bpend_q;
	logic [ValW-1:0]   acc_q;
	logic [ValW-1:0]   hoff_q;
	logic [ValW-1:0]   hcnt_q;
	logic [ValW-1:0]   hsize_q;
	logic [1:0]        htype_q;

	// next state
	etp_pkg::phase_t   phase_d;
	logic [3:0]        hidx_d;
	logic [CountW-1:0] ent_d;
	logic [ValW-1:0]   subs_d;
	logic [1:0]        fidx_d;
	logic [1:0]        bpend_d;
	logic [ValW-1:0]   acc_d;
	logic [ValW-1:0]   hoff_d;
	logic [ValW-1:0]   hcnt_d;
	logic [ValW-1:0]   hsize_d;
	logic [1:0]        htype_d;

	etp_pkg::rec_t     res;
	logic              push;

	// output buffer: slot0 is the head shown on the ports
	etp_pkg::rec_t     slot0_q;
	etp_pkg::rec_t     slot1_q;
	logic [1:0]        cnt_q;

	logic              in_acc;
	logic              pop;

	// parser outside a table, and parser inside the entry list
	logic              idle_byte;
	logic              in_table;

	assign in_stall  = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign in_acc    = in_valid && !in_stall;
	assign pop       = out_valid && !out_stall;

	// ------------------------------------------------------------------
	// per-byte parse step
	// ------------------------------------------------------------------
	always_comb begin
		logic [ValW-1:0] v;
		logic            have_v;
		logic            last;
		phase_d = phase_q;
		hidx_d  = hidx_q;
		ent_d   = ent_q;
		subs_d  = subs_q;
		fidx_d  = fidx_q;
		bpend_d = bpend_q;
		acc_d   = acc_q;
		hoff_d  = hoff_q;
		hcnt_d  = hcnt_q;
		hsize_d = hsize_q;
		htype_d = htype_q;
		res     = '0;
		push    = 1'b0;
		v       = '0;
		have_v  = 1'b0;
		last    = 1'b0;

		if (in_acc) begin
			// start flag restarts the parser whatever it was doing
			if (start_of_table) begin
				phase_d = etp_pkg::PH_HEADER;
				hidx_d  = '0;
				ent_d   = '0;
				subs_d  = '0;
				fidx_d  = '0;
				bpend_d = '0;
				acc_d   = '0;
				hoff_d  = '0;
				hcnt_d  = '0;
				hsize_d = '0;
				htype_d = '0;
			end

			if (phase_d == etp_pkg::PH_HEADER) begin
				// bytes 4..7 carry the entry count, low byte first
				if (hidx_d inside {[4'd4:4'd7]})
					ent_d = ent_d | ({{(CountW-8){1'b0}}, byte_value} << {hidx_d[1:0], 3'b000});
				if (hidx_d == etp_pkg::HdrLast) begin
					hidx_d = '0;
					if (ent_d == '0) begin
						// empty table gives a single closing record
						phase_d  = etp_pkg::PH_DONE;
						res.kind = etp_pkg::KIND_EMPTY;
						res.last = 1'b1;
						push     = 1'b1;
					end else begin
						phase_d = etp_pkg::PH_ENTRY;
						fidx_d  = '0;
					end
				end else begin
					hidx_d = hidx_d + 4'd1;
				end
			end else if (phase_d == etp_pkg::PH_ENTRY || phase_d == etp_pkg::PH_SUB) begin
				if (bpend_d != 2'd0) begin
					// continuation byte of a big-endian value
					acc_d   = {acc_d[ValW-9:0], byte_value};
					bpend_d = bpend_d - 2'd1;
					have_v  = (bpend_d == 2'd0);
				end else begin
					// first byte: typed skip keeps 4 bits, plain values keep 6
					if (phase_d == etp_pkg::PH_SUB && fidx_d == 2'd0) begin
						htype_d = byte_value[5:4];
						acc_d   = {{(ValW-4){1'b0}}, byte_value[3:0]};
					end else begin
						acc_d   = {{(ValW-6){1'b0}}, byte_value[5:0]};
					end
					case (etp_pkg::prefix_t'(byte_value[7:6]))
						etp_pkg::PFX_BAD: begin
							// invalid length: report and wait for a new table
							phase_d  = etp_pkg::PH_DONE;
							acc_d    = '0;
							res.kind = etp_pkg::KIND_INVALID;
							res.last = 1'b1;
							push     = 1'b1;
						end
						etp_pkg::PFX_TWO:  bpend_d = etp_pkg::PendTwo;
						etp_pkg::PFX_FOUR: bpend_d = etp_pkg::PendFour;
						default:           have_v  = 1'b1;
					endcase
				end

				if (have_v) begin
					v     = acc_d;
					acc_d = '0;
					if (phase_d == etp_pkg::PH_ENTRY) begin
						case (fidx_d)
							2'd0: begin
								hoff_d = v;
								fidx_d = 2'd1;
							end
							2'd1: begin
								hcnt_d = v;
								fidx_d = 2'd2;
							end
							2'd2: begin
								hsize_d = v;
								fidx_d  = 2'd3;
							end
							default: begin
								// repeat value closes the entry
								if (hcnt_d != '0 && v != '0) begin
									subs_d  = hcnt_d;
									phase_d = etp_pkg::PH_SUB;
									fidx_d  = 2'd0;
									last    = 1'b0;
								end else begin
									last    = (ent_d == {{(CountW-1){1'b0}}, 1'b1});
									ent_d   = ent_d - {{(CountW-1){1'b0}}, 1'b1};
									fidx_d  = 2'd0;
									phase_d = last ? etp_pkg::PH_DONE : etp_pkg::PH_ENTRY;
								end
								res.kind           = etp_pkg::KIND_ENTRY;
								res.offset_or_skip = hoff_d;
								res.sub_count      = hcnt_d;
								res.element_size   = hsize_d;
								res.repeat_value   = v;
								res.last           = last;
								push               = 1'b1;
							end
						endcase
					end else begin
						if (fidx_d == 2'd0) begin
							hoff_d = v;
							fidx_d = 2'd1;
						end else begin
							// sub-entry done, the last one also closes its entry
							fidx_d = 2'd0;
							if (subs_d == {{(ValW-1){1'b0}}, 1'b1}) begin
								last    = (ent_d == {{(CountW-1){1'b0}}, 1'b1});
								ent_d   = ent_d - {{(CountW-1){1'b0}}, 1'b1};
								phase_d = last ? etp_pkg::PH_DONE : etp_pkg::PH_ENTRY;
							end
							subs_d             = subs_d - {{(ValW-1){1'b0}}, 1'b1};
							res.kind           = etp_pkg::KIND_SUB;
							res.offset_or_skip = hoff_d;
							res.repeat_value   = v;
							res.swap_type      = htype_d;
							res.last           = last;
							push               = 1'b1;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= etp_pkg::PH_IDLE;
			hidx_q  <= '0;
			ent_q   <= '0;
			subs_q  <= '0;
			fidx_q  <= '0;
			bpend_q <= '0;
			acc_q   <= '0;
			hoff_q  <= '0;
			hcnt_q  <= '0;
			hsize_q <= '0;
			htype_q <= '0;
		end else begin
			phase_q <= phase_d;
			hidx_q  <= hidx_d;
			ent_q   <= ent_d;
			subs_q  <= subs_d;
			fidx_q  <= fidx_d;
			bpend_q <= bpend_d;
			acc_q   <= acc_d;
			hoff_q  <= hoff_d;
			hcnt_q  <= hcnt_d;
			hsize_q <= hsize_d;
			htype_q <= htype_d;
		end
	end

	// ------------------------------------------------------------------
	// two-slot result buffer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b11: begin
				if (cnt_q == 2'd1) begin
					slot0_q <= res;
				end else begin
					slot0_q <= slot1_q;
					slot1_q <= res;
				end
			end
			2'b10: begin
				if (cnt_q == 2'd0)
					slot0_q <= res;
				else
					slot1_q <= res;
			end
			2'b01:   slot0_q <= slot1_q;
			default: slot0_q <= slot0_q;
		endcase
	end

	assign record_kind    = slot0_q.kind;
	assign offset_or_skip = slot0_q.offset_or_skip;
	assign sub_count      = slot0_q.sub_count;
	assign element_size   = slot0_q.element_size;
	assign repeat_value   = slot0_q.repeat_value;
	assign swap_type      = slot0_q.swap_type;
	assign last_record    = slot0_q.last;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	assign idle_byte = in_acc && !start_of_table
		&& (phase_q == etp_pkg::PH_IDLE || phase_q == etp_pkg::PH_DONE);
	assign in_table  = (phase_q == etp_pkg::PH_ENTRY || phase_q == etp_pkg::PH_SUB);

	`ASSERT_CLK(a_cnt_range, cnt_q != 2'd3, "result buffer count overflow")
	`ASSERT_CLK(a_no_rec_when_idle, !(idle_byte && push), "record from idle parser")
	`ASSERT_CLK(a_ent_live, !in_table || (ent_q != '0), "entry phase with zero entries left")
	`ASSERT_NEXT(a_last_done, push && res.last, phase_q == etp_pkg::PH_DONE, "not done after last")

endmodule

// ===== test/etp_record_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// etp_record_checker
// watches both channels of the endian table parser, predicts the records
// from the accepted bytes and compares every record that leaves the block
// ----------------------------------------------------------------------------
module etp_record_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  byte_value,
	input  logic        start_of_table,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  record_kind,
	input  logic [29:0] offset_or_skip,
	input  logic [29:0] sub_count,
	input  logic [29:0] element_size,
	input  logic [29:0] repeat_value,
	input  logic [1:0]  swap_type,
	input  logic        last_record,
	output int          fail_count,
	output int          records_owed
);

	// position of a packed value inside an entry or a sub-entry
	localparam logic [1:0] FieldOffset = 2'd0;
	localparam logic [1:0] FieldCount  = 2'd1;
	localparam logic [1:0] FieldSize   = 2'd2;

	etp_pkg::phase_t phase;
	logic [3:0]  hdr_idx;
	logic [31:0] entries_left;
	logic [29:0] subs_left;
	logic [1:0]  field_idx;
	logic [1:0]  bytes_owed;
	logic [29:0] acc;
	logic [29:0] held_offset;
	logic [29:0] held_count;
	logic [29:0] held_size;
	logic [1:0]  held_type;

	etp_pkg::rec_t predicted_records[$];

	task automatic clear_parser();
		phase        = etp_pkg::PH_IDLE;
		hdr_idx      = '0;
		entries_left = '0;
		subs_left    = '0;
		field_idx    = '0;
		bytes_owed   = '0;
		acc          = '0;
		held_offset  = '0;
		held_count   = '0;
		held_size    = '0;
		held_type    = '0;
	endtask

	task automatic queue_record(input etp_pkg::kind_t k, input logic [29:0] a,
			input logic [29:0] b, input logic [29:0] c, input logic [29:0] d,
			input logic [1:0] t, input logic l);
		etp_pkg::rec_t r;
		r.kind           = k;
		r.offset_or_skip = a;
		r.sub_count      = b;
		r.element_size   = c;
		r.repeat_value   = d;
		r.swap_type      = t;
		r.last           = l;
		predicted_records.insert(predicted_records.size(), r);
	endtask

	// count one entry down, returns 1 when it was the final one
	function automatic logic close_entry();
		entries_left = entries_left - 32'd1;
		field_idx    = FieldOffset;
		if (entries_left == 0) begin
			phase = etp_pkg::PH_DONE;
			return 1'b1;
		end
		phase = etp_pkg::PH_ENTRY;
		return 1'b0;
	endfunction

	task automatic parse_table_byte(input logic [7:0] b, input logic sof);
		logic [29:0] v;
		logic        last;
		logic        have_value;
		have_value = 1'b0;
		last       = 1'b0;
		if (sof) begin
			clear_parser();
			phase = etp_pkg::PH_HEADER;
		end
		if (phase == etp_pkg::PH_HEADER) begin
			if (hdr_idx >= 4 && hdr_idx < 8)
				entries_left = entries_left | (32'(b) << (8 * (hdr_idx - 4)));
			if (hdr_idx == etp_pkg::HdrLast) begin
				hdr_idx = '0;
				if (entries_left == 0) begin
					phase = etp_pkg::PH_DONE;
					queue_record(etp_pkg::KIND_EMPTY, '0, '0, '0, '0, '0, 1'b1);
				end else begin
					phase     = etp_pkg::PH_ENTRY;
					field_idx = FieldOffset;
				end
			end else begin
				hdr_idx = hdr_idx + 4'd1;
			end
		end else if (phase == etp_pkg::PH_ENTRY || phase == etp_pkg::PH_SUB) begin
			if (bytes_owed != 0) begin
				acc        = {acc[21:0], b};
				bytes_owed = bytes_owed - 2'd1;
				have_value = (bytes_owed == 0);
			end else begin
				// typed skip keeps only four value bits in its first byte
				if (phase == etp_pkg::PH_SUB && field_idx == FieldOffset) begin
					held_type = b[5:4];
					acc       = {26'd0, b[3:0]};
				end else begin
					acc = {24'd0, b[5:0]};
				end
				case (etp_pkg::prefix_t'(b[7:6]))
					etp_pkg::PFX_BAD: begin
						phase = etp_pkg::PH_DONE;
						acc   = '0;
						queue_record(etp_pkg::KIND_INVALID, '0, '0, '0, '0, '0, 1'b1);
					end
					etp_pkg::PFX_TWO:  bytes_owed = etp_pkg::PendTwo;
					etp_pkg::PFX_FOUR: bytes_owed = etp_pkg::PendFour;
					default:           have_value = 1'b1;
				endcase
			end
			if (have_value) begin
				v   = acc;
				acc = '0;
				if (phase == etp_pkg::PH_ENTRY) begin
					case (field_idx)
						FieldOffset: begin
							held_offset = v;
							field_idx   = FieldCount;
						end
						FieldCount: begin
							held_count = v;
							field_idx  = FieldSize;
						end
						FieldSize: begin
							held_size = v;
							field_idx = 2'd3;
						end
						default: begin
							if (held_count != 0 && v != 0) begin
								subs_left = held_count;
								phase     = etp_pkg::PH_SUB;
								field_idx = FieldOffset;
							end else begin
								last = close_entry();
							end
							queue_record(etp_pkg::KIND_ENTRY, held_offset, held_count,
								held_size, v, '0, last);
						end
					endcase
				end else if (field_idx == FieldOffset) begin
					held_offset = v;
					field_idx   = FieldCount;
				end else begin
					field_idx = FieldOffset;
					subs_left = subs_left - 30'd1;
					if (subs_left == 0)
						last = close_entry();
					queue_record(etp_pkg::KIND_SUB, held_offset, '0, '0, v, held_type, last);
				end
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		etp_pkg::rec_t want;
		if (!arst_n) begin
			clear_parser();
			predicted_records.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (predicted_records.size() == 0) begin
					$display("%0t ns: record of kind %0d with none expected", $time,
						record_kind);
					fail_count++;
				end else begin
					want = predicted_records.pop_front();
					check_field("record_kind", 32'(want.kind), 32'(record_kind));
					check_field("offset_or_skip", 32'(want.offset_or_skip), 32'(offset_or_skip));
					check_field("sub_count", 32'(want.sub_count), 32'(sub_count));
					check_field("element_size", 32'(want.element_size), 32'(element_size));
					check_field("repeat_value", 32'(want.repeat_value), 32'(repeat_value));
					check_field("swap_type", 32'(want.swap_type), 32'(swap_type));
					check_field("last_record", 32'(want.last), 32'(last_record));
				end
			end
			if (in_valid && !in_stall)
				parse_table_byte(byte_value, start_of_table);
		end
		records_owed = predicted_records.size();
	end

endmodule

// ===== test/tb_endian_table_parser_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_endian_table_parser_unit
// feeds endian-relocation tables into the parser byte by byte: a short
// directed stream, then random tables with subs, errors, cuts and noise,
// under three idle patterns; the checker beside the block scores the records
// ----------------------------------------------------------------------------
module tb_endian_table_parser_unit;

	// bytes to send before the stream stops, split in three idle phases
	localparam int StreamBytes = 1750;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  byte_value;
	logic        start_of_table;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  record_kind;
	logic [29:0] offset_or_skip;
	logic [29:0] sub_count;
	logic [29:0] element_size;
	logic [29:0] repeat_value;
	logic [1:0]  swap_type;
	logic        last_record;

	int fail_count;
	int records_owed;

	// idle chances in percent, changed per phase
	int src_idle_pct;
	int snk_stall_pct;
	int bytes_sent;

	// stream waiting to go out: {start_of_table, byte}
	logic [8:0] table_bytes[$];

	// error and cut injection for the random tables
	int   value_idx;
	int   bad_value_idx;
	int   cut_value_idx;
	logic table_broken;

	endian_table_parser_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.byte_value     (byte_value),
		.start_of_table (start_of_table),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.record_kind    (record_kind),
		.offset_or_skip (offset_or_skip),
		.sub_count      (sub_count),
		.element_size   (element_size),
		.repeat_value   (repeat_value),
		.swap_type      (swap_type),
		.last_record    (last_record)
	);

	etp_record_checker records_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.byte_value     (byte_value),
		.start_of_table (start_of_table),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.record_kind    (record_kind),
		.offset_or_skip (offset_or_skip),
		.sub_count      (sub_count),
		.element_size   (element_size),
		.repeat_value   (repeat_value),
		.swap_type      (swap_type),
		.last_record    (last_record),
		.fail_count     (fail_count),
		.records_owed   (records_owed)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver stalls at random, independent of valid
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < snk_stall_pct);
	end

	task automatic push_byte(input logic [7:0] b, input logic sof);
		table_bytes.insert(table_bytes.size(), {sof, b});
	endtask

	// packed value with 1, 2 or 4 bytes, too-wide values are cut to fit
	task automatic push_packed(input logic [29:0] v, input int nbytes, input logic typed,
			input logic [1:0] ty);
		case (nbytes)
			1: push_byte({etp_pkg::PFX_ONE, typed ? {ty, v[3:0]} : v[5:0]}, 1'b0);
			2: begin
				push_byte({etp_pkg::PFX_TWO, typed ? {ty, v[11:8]} : v[13:8]}, 1'b0);
				push_byte(v[7:0], 1'b0);
			end
			default: begin
				push_byte({etp_pkg::PFX_FOUR, typed ? {ty, v[27:24]} : v[29:24]}, 1'b0);
				push_byte(v[23:16], 1'b0);
				push_byte(v[15:8], 1'b0);
				push_byte(v[7:0], 1'b0);
			end
		endcase
	endtask

	// 16 header bytes, entry count little-endian in bytes 4..7, rest is junk
	task automatic push_header(input logic [31:0] count);
		logic [7:0] b;
		for (int h = 0; h < 16; h++) begin
			b = 8'($urandom);
			if (h >= 4 && h < 8)
				b = count[8 * (h - 4) +: 8];
			push_byte(b, h == 0);
		end
	endtask

	function automatic int rand_len();
		case ($urandom_range(2))
			0:       return 1;
			1:       return 2;
			default: return 4;
		endcase
	endfunction

	function automatic logic [29:0] rand_value();
		case ($urandom_range(7))
			0:       return '0;
			1:       return 30'h3FFF_FFFF;
			2:       return 30'($urandom_range(63));
			default: return 30'($urandom);
		endcase
	endfunction

	// next packed value of a random table, or the error or cut planned here
	task automatic emit_value(input logic [29:0] v, input logic typed, input logic [1:0] ty);
		if (!table_broken) begin
			if (value_idx == bad_value_idx) begin
				// prefix 3 on a first byte
				push_byte({etp_pkg::PFX_BAD, 6'($urandom)}, 1'b0);
				table_broken = 1'b1;
			end else if (value_idx == cut_value_idx) begin
				// sometimes leave a long value half read before the next start
				if ($urandom_range(1))
					push_byte({etp_pkg::PFX_FOUR, 6'($urandom)}, 1'b0);
				table_broken = 1'b1;
			end else begin
				push_packed(v, rand_len(), typed, ty);
			end
			value_idx++;
		end
	endtask

	task automatic build_random_table();
		logic [31:0] count;
		logic [29:0] cnt;
		logic [29:0] rep;
		int          n_entries;
		int          n_subs;
		int          shape;
		value_idx     = 0;
		table_broken  = 1'b0;
		bad_value_idx = ($urandom_range(99) < 10) ? $urandom_range(12) : -1;
		cut_value_idx = ($urandom_range(99) < 6) ? $urandom_range(12) : -1;
		shape = $urandom_range(99);
		if (shape < 4)
			count = '0;
		else if (shape < 7)
			count = $urandom | 32'h8000_0000;  // never finishes, next start cuts it
		else
			count = $urandom_range(1, 4);
		push_header(count);
		n_entries = (count > 5) ? 5 : count;
		for (int i = 0; i < n_entries; i++) begin
			n_subs = 0;
			case ($urandom_range(3))
				0, 1: begin
					n_subs = $urandom_range(1, 3);
					cnt    = 30'(n_subs);
					rep    = 30'($urandom_range(1, 63));
				end
				2: begin
					cnt = '0;
					rep = rand_value();
				end
				default: begin
					// random sub count but no repeat, so no sub-entries
					cnt = rand_value();
					rep = '0;
				end
			endcase
			emit_value(rand_value(), 1'b0, '0);
			emit_value(cnt, 1'b0, '0);
			emit_value(rand_value(), 1'b0, '0);
			emit_value(rep, 1'b0, '0);
			for (int j = 0; j < n_subs; j++) begin
				emit_value(rand_value(), 1'b1, 2'($urandom));
				emit_value(rand_value(), 1'b0, '0);
			end
		end
		// trailing bytes without a start flag, ignored once the table is over
		if ($urandom_range(3) == 0)
			for (int k = $urandom_range(1, 3); k > 0; k--)
				push_byte(8'($urandom), 1'b0);
	endtask

	// send everything queued, one handshake per byte
	task automatic send_stream();
		logic [8:0] item;
		while (table_bytes.size() != 0) begin
			item = table_bytes.pop_front();
			if (bytes_sent < StreamBytes / 3) begin
				src_idle_pct  = 26;
				snk_stall_pct = 82;
			end else if (bytes_sent < 2 * StreamBytes / 3) begin
				src_idle_pct  = 82;
				snk_stall_pct = 26;
			end else begin
				src_idle_pct  = 0;
				snk_stall_pct = 0;
			end
			while ($urandom_range(99) < src_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid       <= 1'b1;
			byte_value     <= item[7:0];
			start_of_table <= item[8];
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
			bytes_sent++;
		end
	endtask

	initial begin
		src_idle_pct   = 0;
		snk_stall_pct  = 0;
		bytes_sent     = 0;
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		byte_value     <= '0;
		start_of_table <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: noise while idle, then a table with an all-ones count
		push_byte(8'hFF, 1'b0);
		push_header(32'hFFFF_FFFF);
		// entry at the field maxima, sub count kept although repeat is zero
		push_packed(30'h3FFF_FFFF, 4, 1'b0, '0);
		push_packed(30'h3FFF_FFFF, 4, 1'b0, '0);
		push_packed(30'h3FFF_FFFF, 4, 1'b0, '0);
		push_packed('0, 1, 1'b0, '0);
		// entry with one sub-entry, widest skip and repeat
		push_packed('0, 1, 1'b0, '0);
		push_packed(30'd1, 2, 1'b0, '0);
		push_packed('0, 2, 1'b0, '0);
		push_packed(30'h3FFF_FFFF, 4, 1'b0, '0);
		push_packed(30'h0FFF_FFFF, 4, 1'b1, 2'd3);
		push_packed(30'h3FFF_FFFF, 4, 1'b0, '0);
		// restart while a long value is half read, into an empty table
		push_byte(8'h80, 1'b0);
		push_header('0);
		// ignored once the empty table is done
		push_byte(8'h5A, 1'b0);
		send_stream();

		// random tables until the byte budget is used up
		while (bytes_sent < StreamBytes) begin
			build_random_table();
			send_stream();
		end
		in_valid <= 1'b0;

		// drain: sample the owed count away from the clock edge
		do
			@(negedge clk);
		while (records_owed != 0);
		repeat (16) @(posedge clk);

		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
